// ===== hw/rtl/rea_pkg.sv =====
// ----------------------------------------------------------------------------
// rea_pkg
// Shared types, register map and reset constants for the rotary encoder
// position tracker.
// ----------------------------------------------------------------------------
package rea_pkg;

  localparam int unsigned POS_W     = 12;
  localparam int unsigned MOD_W     = 13;
  localparam int unsigned STEP_W    = 8;
  localparam int unsigned THR_W     = 8;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned RED_LANES = 4;

  localparam logic [MOD_W-1:0]  MOD_FULL    = 13'd4096;
  localparam logic [MOD_W-1:0]  MODULUS_RST = 13'd360;
  localparam logic [POS_W-1:0]  HOME_RST    = 12'd180;
  localparam logic [STEP_W-1:0] SLOW_RST    = 8'd1;
  localparam logic [STEP_W-1:0] FAST_RST    = 8'd5;
  localparam logic [THR_W-1:0]  THR_RST     = 8'd5;
  localparam logic [TICK_W-1:0] TICKS_RST   = 16'd150;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WRAP_MODULUS   = 3'd0,
    REG_HOME_POSITION  = 3'd1,
    REG_SLOW_STEP      = 3'd2,
    REG_FAST_STEP      = 3'd3,
    REG_FAST_THRESHOLD = 3'd4,
    REG_WINDOW_TICKS   = 3'd5
  } reg_idx_e;

  typedef enum logic {
    CMD_PIN  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // Settings seen by the tracking logic; modulus is already the effective one.
  typedef struct packed {
    logic [MOD_W-1:0]  modulus;
    logic [THR_W-1:0]  threshold;
    logic [TICK_W-1:0] window_ticks;
  } cfg_t;

  // Values kept reduced below the modulus.
  typedef struct packed {
    logic [POS_W-1:0] dial;
    logic [POS_W-1:0] home;
    logic [POS_W-1:0] slow;
    logic [POS_W-1:0] fast;
  } red_t;

endpackage

// ===== hw/rtl/rea_regs.sv =====
// ----------------------------------------------------------------------------
// rea_regs
// Configuration registers behind the APB-style port, with the effective
// modulus and a pulse that requests a new reduction pass.
// ----------------------------------------------------------------------------
module rea_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [rea_pkg::ADDR_W-1:0]    paddr_i,
  input  logic [rea_pkg::DATA_W-1:0]    pwdata_i,
  output logic [rea_pkg::DATA_W-1:0]    prdata_o,
  output rea_pkg::cfg_t                 cfg_o,
  output logic [rea_pkg::POS_W-1:0]     home_o,
  output logic [rea_pkg::STEP_W-1:0]    slow_o,
  output logic [rea_pkg::STEP_W-1:0]    fast_o,
  output logic                          reduce_start_o
);

  logic [rea_pkg::MOD_W-1:0]  wrap_q;
  logic [rea_pkg::POS_W-1:0]  home_q;
  logic [rea_pkg::STEP_W-1:0] slow_q;
  logic [rea_pkg::STEP_W-1:0] fast_q;
  logic [rea_pkg::THR_W-1:0]  thr_q;
  logic [rea_pkg::TICK_W-1:0] ticks_q;
  logic                       reduce_start_q;
  logic                       wr_en;
  rea_pkg::reg_idx_e          idx;

  assign wr_en = psel_i & penable_i & pwrite_i;
  assign idx   = rea_pkg::reg_idx_e'(paddr_i[rea_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q         <= rea_pkg::MODULUS_RST;
      home_q         <= rea_pkg::HOME_RST;
      slow_q         <= rea_pkg::SLOW_RST;
      fast_q         <= rea_pkg::FAST_RST;
      thr_q          <= rea_pkg::THR_RST;
      ticks_q        <= rea_pkg::TICKS_RST;
      reduce_start_q <= 1'b0;
    end else begin
      reduce_start_q <= 1'b0;
      if (wr_en) begin
        unique case (idx)
          rea_pkg::REG_WRAP_MODULUS: begin
            wrap_q         <= pwdata_i[rea_pkg::MOD_W-1:0];
            reduce_start_q <= 1'b1;
          end
          rea_pkg::REG_HOME_POSITION: begin
            home_q         <= pwdata_i[rea_pkg::POS_W-1:0];
            reduce_start_q <= 1'b1;
          end
          rea_pkg::REG_SLOW_STEP: begin
            slow_q         <= pwdata_i[rea_pkg::STEP_W-1:0];
            reduce_start_q <= 1'b1;
          end
          rea_pkg::REG_FAST_STEP: begin
            fast_q         <= pwdata_i[rea_pkg::STEP_W-1:0];
            reduce_start_q <= 1'b1;
          end
          rea_pkg::REG_FAST_THRESHOLD: thr_q   <= pwdata_i[rea_pkg::THR_W-1:0];
          rea_pkg::REG_WINDOW_TICKS:   ticks_q <= pwdata_i[rea_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      rea_pkg::REG_WRAP_MODULUS:
        prdata_o = {{(rea_pkg::DATA_W-rea_pkg::MOD_W){1'b0}}, wrap_q};
      rea_pkg::REG_HOME_POSITION:
        prdata_o = {{(rea_pkg::DATA_W-rea_pkg::POS_W){1'b0}}, home_q};
      rea_pkg::REG_SLOW_STEP:
        prdata_o = {{(rea_pkg::DATA_W-rea_pkg::STEP_W){1'b0}}, slow_q};
      rea_pkg::REG_FAST_STEP:
        prdata_o = {{(rea_pkg::DATA_W-rea_pkg::STEP_W){1'b0}}, fast_q};
      rea_pkg::REG_FAST_THRESHOLD:
        prdata_o = {{(rea_pkg::DATA_W-rea_pkg::THR_W){1'b0}}, thr_q};
      rea_pkg::REG_WINDOW_TICKS:
        prdata_o = {{(rea_pkg::DATA_W-rea_pkg::TICK_W){1'b0}}, ticks_q};
      default:
        prdata_o = '0;
    endcase
  end

  // A modulus of zero or above a full 12-bit range behaves as 4096.
  always_comb begin
    cfg_o.modulus = wrap_q;
    if (wrap_q == '0 || wrap_q > rea_pkg::MOD_FULL) begin
      cfg_o.modulus = rea_pkg::MOD_FULL;
    end
    cfg_o.threshold    = thr_q;
    cfg_o.window_ticks = ticks_q;
  end

  assign home_o         = home_q;
  assign slow_o         = slow_q;
  assign fast_o         = fast_q;
  assign reduce_start_o = reduce_start_q;

endmodule

// ===== hw/rtl/rea_reduce.sv =====
// ----------------------------------------------------------------------------
// rea_reduce
// Bit-serial remainder unit: four lanes of restoring reduction by the
// modulus, one operand bit per lane and cycle.
// ----------------------------------------------------------------------------
module rea_reduce (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rea_pkg::MOD_W-1:0] modulus_i,
  input  rea_pkg::red_t             operand_i,
  output logic                      busy_o,
  output logic                      done_o,
  output rea_pkg::red_t             result_o
);

  localparam int unsigned CNT_W = $clog2(rea_pkg::POS_W + 1);

  logic [rea_pkg::POS_W-1:0] x_q [rea_pkg::RED_LANES];
  logic [rea_pkg::POS_W-1:0] r_q [rea_pkg::RED_LANES];
  logic [rea_pkg::POS_W-1:0] r_d [rea_pkg::RED_LANES];
  logic [rea_pkg::POS_W-1:0] op  [rea_pkg::RED_LANES];
  logic [rea_pkg::MOD_W-1:0] m_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q;

  assign op[0] = operand_i.dial;
  assign op[1] = operand_i.home;
  assign op[2] = operand_i.slow;
  assign op[3] = operand_i.fast;

  // The partial remainder stays below the modulus, so it fits the position width.
  always_comb begin
    logic [rea_pkg::MOD_W-1:0] t;
    logic [rea_pkg::MOD_W-1:0] diff;
    for (int l = 0; l < rea_pkg::RED_LANES; l++) begin
      t    = {r_q[l], x_q[l][rea_pkg::POS_W-1]};
      diff = t - m_q;
      r_d[l] = (t >= m_q) ? diff[rea_pkg::POS_W-1:0] : t[rea_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(rea_pkg::POS_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q <= modulus_i;
      for (int l = 0; l < rea_pkg::RED_LANES; l++) begin
        x_q[l] <= op[l];
        r_q[l] <= '0;
      end
    end else if (busy_q) begin
      for (int l = 0; l < rea_pkg::RED_LANES; l++) begin
        x_q[l] <= {x_q[l][rea_pkg::POS_W-2:0], 1'b0};
        r_q[l] <= r_d[l];
      end
    end
  end

  // The last step's remainders are handed over as they are registered.
  assign busy_o          = busy_q;
  assign done_o          = busy_q & (cnt_q == CNT_W'(1));
  assign result_o.dial   = r_d[0];
  assign result_o.home   = r_d[1];
  assign result_o.slow   = r_d[2];
  assign result_o.fast   = r_d[3];

endmodule

// ===== hw/rtl/rea_track.sv =====
// ----------------------------------------------------------------------------
// rea_track
// Dial state and the combinational update for one transaction: click decode,
// accelerated step with wrap, home load, click history windows.
// ----------------------------------------------------------------------------
module rea_track #(
  parameter int unsigned HISTORY_WINDOWS = 4,
  parameter int unsigned COUNT_WIDTH     = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic                      command_i,
  input  logic                      pin_a_i,
  input  logic                      pin_b_i,
  input  logic                      button_level_i,
  input  rea_pkg::cfg_t             cfg_i,
  input  logic                      red_load_i,
  input  rea_pkg::red_t             red_i,
  output logic [rea_pkg::POS_W-1:0] dial_o,
  output logic [rea_pkg::POS_W-1:0] position_o,
  output logic                      changed_o
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > rea_pkg::THR_W) ? COUNT_WIDTH
                                                                : rea_pkg::THR_W;
  localparam int unsigned SUM_W = rea_pkg::MOD_W + 1;

  logic [rea_pkg::POS_W-1:0]  dial_q, dial_red_q, home_red_q, slow_red_q, fast_red_q;
  logic [COUNT_WIDTH-1:0]     counts_q [HISTORY_WINDOWS];
  logic [rea_pkg::TICK_W-1:0] div_q;
  logic                       last_b_q, last_btn_q, primed_q;

  logic [rea_pkg::TICK_W-1:0] div_inc;
  logic                       win_end, is_tick, click, btn_chg, fast;
  logic [rea_pkg::POS_W-1:0]  step;
  logic [SUM_W-1:0]           mod_x, up_sum, down_sum, sum, wrapped;
  logic [rea_pkg::POS_W-1:0]  dial_next, dial_red_next;

  assign is_tick = (rea_pkg::cmd_e'(command_i) == rea_pkg::CMD_TICK);
  assign div_inc = div_q + 1'b1;
  assign win_end = (div_inc >= cfg_i.window_ticks);

  // Acceleration looks only at the finished windows, not the current one.
  always_comb begin
    fast = 1'b0;
    for (int i = 1; i < HISTORY_WINDOWS; i++) begin
      if (CMP_W'(counts_q[i]) > CMP_W'(cfg_i.threshold)) begin
        fast = 1'b1;
      end
    end
  end

  assign click   = primed_q & ~is_tick & (pin_b_i != last_b_q) & pin_a_i;
  assign btn_chg = primed_q & ~is_tick & (button_level_i != last_btn_q);

  assign step     = fast ? fast_red_q : slow_red_q;
  assign mod_x    = {1'b0, cfg_i.modulus};
  assign up_sum   = SUM_W'(dial_red_q) + SUM_W'(step);
  assign down_sum = SUM_W'(dial_red_q) + mod_x - SUM_W'(step);
  assign sum      = pin_b_i ? up_sum : down_sum;
  assign wrapped  = (sum >= mod_x) ? (sum - mod_x) : sum;

  // A button change wins over a click in the same transaction.
  always_comb begin
    dial_next     = dial_q;
    dial_red_next = dial_red_q;
    if (btn_chg) begin
      dial_next     = home_red_q;
      dial_red_next = home_red_q;
    end else if (click) begin
      dial_next     = wrapped[rea_pkg::POS_W-1:0];
      dial_red_next = wrapped[rea_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dial_q     <= rea_pkg::HOME_RST;
      dial_red_q <= rea_pkg::HOME_RST;
      home_red_q <= rea_pkg::HOME_RST;
      slow_red_q <= {{(rea_pkg::POS_W-rea_pkg::STEP_W){1'b0}}, rea_pkg::SLOW_RST};
      fast_red_q <= {{(rea_pkg::POS_W-rea_pkg::STEP_W){1'b0}}, rea_pkg::FAST_RST};
      for (int i = 0; i < HISTORY_WINDOWS; i++) begin
        counts_q[i] <= '0;
      end
      div_q      <= '0;
      last_b_q   <= 1'b0;
      last_btn_q <= 1'b0;
      primed_q   <= 1'b0;
    end else if (fire_i) begin
      if (is_tick) begin
        if (win_end) begin
          div_q <= '0;
          for (int i = HISTORY_WINDOWS - 1; i > 0; i--) begin
            counts_q[i] <= counts_q[i-1];
          end
          counts_q[0] <= '0;
        end else begin
          div_q <= div_inc;
        end
      end else begin
        last_b_q   <= pin_b_i;
        last_btn_q <= button_level_i;
        primed_q   <= 1'b1;
        dial_q     <= dial_next;
        dial_red_q <= dial_red_next;
        if (click && counts_q[0] != '1) begin
          counts_q[0] <= counts_q[0] + 1'b1;
        end
      end
    end else if (red_load_i) begin
      dial_red_q <= red_i.dial;
      home_red_q <= red_i.home;
      slow_red_q <= red_i.slow;
      fast_red_q <= red_i.fast;
    end
  end

  assign dial_o     = dial_q;
  assign position_o = dial_next;
  assign changed_o  = click | btn_chg;

endmodule

// ===== hw/rtl/rotary_encoder_accelerated_position.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_accelerated_position
// Rotary encoder decoder with click acceleration and a wrapping dial value.
// ----------------------------------------------------------------------------
// Each input transaction is either a pin sample (A, B, button levels) or a
// timer tick, and it yields exactly one output transaction carrying the dial
// position after it and a flag telling whether the position was stepped or
// sent home. Both channels are valid/stall; the block stalls its input side.
// An input transaction is registered in the input stage, updated
// combinationally and held in an output register; a stalled output holds
// it in the input stage until the output register frees up.
// Throughput is one transaction per cycle as long as no reduction runs
// and the receiver does not stall; a stalled result stays put and at most
// one more transaction is taken in behind it before the input stalls too.
// Writes to the modulus, home position or either step start a bit-serial
// reduction of the stored values by the modulus in a shared remainder unit;
// the input is stalled until the reduction is done. The other registers
// take effect at once. Reset loads the register defaults, puts the dial at
// the default home position and clears the click history; the first pin
// sample after reset only records the pin levels.
// ----------------------------------------------------------------------------
module rotary_encoder_accelerated_position #(
  parameter int unsigned HISTORY_WINDOWS = 4,
  parameter int unsigned COUNT_WIDTH     = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic                          pin_a_i,
  input  logic                          pin_b_i,
  input  logic                          button_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rea_pkg::POS_W-1:0]     position_o,
  output logic                          changed_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rea_pkg::ADDR_W-1:0]    paddr,
  input  logic [rea_pkg::DATA_W-1:0]    pwdata,
  output logic [rea_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  rea_pkg::cfg_t              cfg;
  rea_pkg::red_t              operand, red_result;
  logic [rea_pkg::POS_W-1:0]  home, dial, next_pos;
  logic [rea_pkg::STEP_W-1:0] slow, fast;
  logic                       reduce_start, reduce_busy, reduce_done, next_changed;

  logic                       s1_valid_q, s1_cmd_q, s1_a_q, s1_b_q, s1_btn_q;
  logic                       s1_fire, s1_take;
  logic                       out_valid_q, out_changed_q;
  logic [rea_pkg::POS_W-1:0]  out_pos_q;

  rea_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .cfg_o          (cfg),
    .home_o         (home),
    .slow_o         (slow),
    .fast_o         (fast),
    .reduce_start_o (reduce_start)
  );

  assign operand.dial = dial;
  assign operand.home = home;
  assign operand.slow = {{(rea_pkg::POS_W-rea_pkg::STEP_W){1'b0}}, slow};
  assign operand.fast = {{(rea_pkg::POS_W-rea_pkg::STEP_W){1'b0}}, fast};

  rea_reduce u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (reduce_start),
    .modulus_i (cfg.modulus),
    .operand_i (operand),
    .busy_o    (reduce_busy),
    .done_o    (reduce_done),
    .result_o  (red_result)
  );

  rea_track #(
    .HISTORY_WINDOWS (HISTORY_WINDOWS),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (s1_fire),
    .command_i      (s1_cmd_q),
    .pin_a_i        (s1_a_q),
    .pin_b_i        (s1_b_q),
    .button_level_i (s1_btn_q),
    .cfg_i          (cfg),
    .red_load_i     (reduce_done),
    .red_i          (red_result),
    .dial_o         (dial),
    .position_o     (next_pos),
    .changed_o      (next_changed)
  );

  // The input stage moves on whenever the output register is free or leaving.
  assign s1_fire    = s1_valid_q & ~(out_valid_q & out_stall_i);
  assign in_stall_o = reduce_start | reduce_busy | (s1_valid_q & ~s1_fire);
  assign s1_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_take | (s1_valid_q & ~s1_fire);
      out_valid_q <= s1_fire | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      s1_cmd_q <= command_i;
      s1_a_q   <= pin_a_i;
      s1_b_q   <= pin_b_i;
      s1_btn_q <= button_level_i;
    end
    if (s1_fire) begin
      out_pos_q     <= next_pos;
      out_changed_q <= next_changed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = out_pos_q;
  assign changed_o   = out_changed_q;
  assign pready      = 1'b1;

endmodule
